// ----- rtl/core/rmcd_pkg.sv -----
// shared constants and types for the red mask change detector
package rmcd_pkg;

	localparam int MAX_SAMPLES = 2048;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	localparam int CH_W        = 8;
	localparam int OUT_CNT_W   = 12;
	localparam int PCT_W       = 7;
	localparam int PML_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_REDNESS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIMILARITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE   = 2'd2;

	localparam logic [PCT_W-1:0] REDNESS_RST    = 7'd60;
	localparam logic [PCT_W-1:0] SIMILARITY_RST = 7'd90;
	localparam logic [PML_W-1:0] PRESENCE_RST   = 10'd1;

	localparam logic CMD_STORE   = 1'b0;
	localparam logic CMD_COMPARE = 1'b1;

	typedef struct packed {
		logic [PCT_W-1:0] redness_percent;
		logic [PCT_W-1:0] similarity_percent;
		logic [PML_W-1:0] presence_permille;
	} cfg_t;

endpackage

// ----- rtl/core/rmcd_if.sv -----
// pixel request and frame result channel interfaces
interface rmcd_pixel_if;
	import rmcd_pkg::*;

	logic            valid;
	logic            ready;
	logic            cmd;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic            last;

	modport source (output valid, cmd, red, green, blue, last, input ready);
	modport sink   (input valid, cmd, red, green, blue, last, output ready);
endinterface

interface rmcd_result_if;
	import rmcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 present;
	logic                 similar;
	logic [OUT_CNT_W-1:0] red_count;
	logic [OUT_CNT_W-1:0] match_count;
	logic [OUT_CNT_W-1:0] sample_count;
	logic                 overflow;

	modport source (output valid, present, similar, red_count, match_count, sample_count,
		overflow, input ready);
	modport sink   (input valid, present, similar, red_count, match_count, sample_count,
		overflow, output ready);
endinterface

// ----- rtl/core/rmcd_ram.sv -----
// generic single write port ram with registered read
module rmcd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/rmcd_classify.sv -----
// per pixel redness test by integer cross multiplication
module rmcd_classify (
	input  logic [rmcd_pkg::CH_W-1:0]  red,
	input  logic [rmcd_pkg::CH_W-1:0]  green,
	input  logic [rmcd_pkg::CH_W-1:0]  blue,
	input  logic [rmcd_pkg::PCT_W-1:0] redness_percent,
	output logic                       mark
);
	import rmcd_pkg::*;

	localparam int SUM_W = CH_W + 2;
	localparam int LHS_W = CH_W + 7;
	localparam int RHS_W = SUM_W + PCT_W;

	logic [SUM_W-1:0] sum;
	logic [LHS_W-1:0] lhs;
	logic [RHS_W-1:0] rhs;

	always_comb begin
		sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		lhs  = LHS_W'(red) * LHS_W'(100);
		rhs  = RHS_W'(redness_percent) * RHS_W'(sum);
		mark = RHS_W'(lhs) > rhs;
	end
endmodule

// ----- rtl/core/red_mask_change_detector.sv -----
// top level of the red mask change detector
// Takes one pixel request per cycle unless stalled, and marks it red when
// red*100 > redness_percent*(r+g+b). Store frames (cmd 0) write the mark into
// a 2048 x 1 reference ram, compare frames (cmd 1) read it back and count
// matches. The request with last set returns one result via stage 1, stage 2
// and the result register; other requests return nothing. The ram read is
// issued at acceptance and used in stage 1, with a bypass for a single-sample
// store frame followed at once by a compare. Pixels keep flowing while results
// wait; a frame end stalls only while two earlier results are both untaken.
// The reference ram is not cleared at reset, so compare frames are meaningful
// only after a store frame of at least the same length. Configuration is
// written through cfg_we/cfg_index/cfg_data while no frame is in flight.
module red_mask_change_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmcd_pkg::CFG_DATA_W-1:0] cfg_data,
	rmcd_pixel_if.sink                     pix,
	rmcd_result_if.source                  res
);
	import rmcd_pkg::*;

	localparam int PW = CNT_W + PML_W;
	localparam int SW = CNT_W + PCT_W;

	cfg_t cfg_q;

	// front counter
	logic [CNT_W-1:0] idx_q;
	logic             in_acc;
	logic             in_rng;

	// stage 1
	logic             valid_s1;
	logic             cmd_s1;
	logic [CH_W-1:0]  red_s1;
	logic [CH_W-1:0]  green_s1;
	logic [CH_W-1:0]  blue_s1;
	logic             last_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             inrng_s1;
	logic             byp_s1;
	logic             bypd_s1;

	logic [CNT_W-1:0] red_tot_q;
	logic [CNT_W-1:0] match_tot_q;
	logic             ovf_q;

	// stage 2
	logic             valid_s2;
	logic             cmd_s2;
	logic [CNT_W-1:0] red_s2;
	logic [CNT_W-1:0] match_s2;
	logic [CNT_W-1:0] n_s2;
	logic             ovf_s2;

	logic             out_valid_q;
	logic             out_free;
	logic             s2_free;
	logic             s1_adv;

	logic             mark;
	logic             ref_bit;
	logic             match;
	logic             ram_we;
	logic             ram_rd;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;

	logic [CNT_W-1:0] red_fin;
	logic [CNT_W-1:0] match_fin;
	logic [CNT_W-1:0] n_fin;

	logic [PW-1:0]    pres_l;
	logic [PW-1:0]    pres_r;
	logic [SW-1:0]    sim_l;
	logic [SW-1:0]    sim_r;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.redness_percent    <= REDNESS_RST;
			cfg_q.similarity_percent <= SIMILARITY_RST;
			cfg_q.presence_permille  <= PRESENCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REDNESS:    cfg_q.redness_percent    <= cfg_data[PCT_W-1:0];
				CFG_SIMILARITY: cfg_q.similarity_percent <= cfg_data[PCT_W-1:0];
				CFG_PRESENCE:   cfg_q.presence_permille  <= cfg_data[PML_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	always_comb begin
		out_free  = !out_valid_q || res.ready;
		s2_free   = !valid_s2 || out_free;
		s1_adv    = valid_s1 && (!last_s1 || s2_free);
		pix.ready = !valid_s1 || s1_adv;
		in_acc    = pix.valid && pix.ready;
		in_rng    = idx_q < CNT_W'(MAX_SAMPLES);
	end

	rmcd_classify u_classify (
		.red             (red_s1),
		.green           (green_s1),
		.blue            (blue_s1),
		.redness_percent (cfg_q.redness_percent),
		.mark            (mark)
	);

	always_comb begin
		ram_rd    = in_acc;
		ram_raddr = idx_q[ADDR_W-1:0];
		ram_we    = s1_adv && inrng_s1 && (cmd_s1 == CMD_STORE);
		ram_waddr = idx_s1[ADDR_W-1:0];
	end

	logic ram_rdata;

	rmcd_ram #(
		.WIDTH (1),
		.DEPTH (MAX_SAMPLES)
	) u_ref_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mark),
		.re    (ram_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ref_bit   = byp_s1 ? bypd_s1 : ram_rdata;
		match     = inrng_s1 && (cmd_s1 == CMD_COMPARE) && (ref_bit == mark);
		red_fin   = red_tot_q + CNT_W'(inrng_s1 && mark);
		match_fin = match_tot_q + CNT_W'(match);
		n_fin     = idx_s1 + CNT_W'(inrng_s1);
	end

	// front sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_acc) begin
			if (pix.last) begin
				idx_q <= '0;
			end else if (in_rng) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= pix.cmd;
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			last_s1  <= pix.last;
			idx_s1   <= idx_q;
			inrng_s1 <= in_rng;
			byp_s1   <= ram_we && (ram_waddr == ram_raddr);
			bypd_s1  <= mark;
		end
	end

	// stage 1 valid and frame totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			red_tot_q   <= '0;
			match_tot_q <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (pix.ready) begin
				valid_s1 <= pix.valid;
			end
			if (s1_adv) begin
				if (last_s1) begin
					red_tot_q   <= '0;
					match_tot_q <= '0;
					ovf_q       <= 1'b0;
				end else begin
					red_tot_q   <= red_fin;
					match_tot_q <= match_fin;
					ovf_q       <= ovf_q || !inrng_s1;
				end
			end
		end
	end

	// stage 2 frame summary
	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			cmd_s2   <= cmd_s1;
			red_s2   <= red_fin;
			match_s2 <= match_fin;
			n_s2     <= n_fin;
			ovf_s2   <= ovf_q || !inrng_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	// threshold tests
	always_comb begin
		pres_l = PW'(red_s2) * PW'(1000);
		pres_r = PW'(cfg_q.presence_permille) * PW'(n_s2);
		sim_l  = SW'(match_s2) * SW'(100);
		sim_r  = SW'(cfg_q.similarity_percent) * SW'(n_s2);
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			res.present      <= pres_l > pres_r;
			res.similar      <= (cmd_s2 == CMD_COMPARE) && (sim_l > sim_r);
			res.red_count    <= OUT_CNT_W'(red_s2);
			res.match_count  <= (cmd_s2 == CMD_COMPARE) ? OUT_CNT_W'(match_s2) : '0;
			res.sample_count <= OUT_CNT_W'(n_s2);
			res.overflow     <= ovf_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid = out_valid_q;

	// checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pix.ready)
		else $error("pixel request refused with stage 1 empty");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |-> last_s1 && valid_s2 && out_valid_q && !res.ready)
		else $error("stage 1 stalled without a blocked frame result");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.match_count <= res.sample_count &&
			res.red_count <= res.sample_count)
		else $error("count exceeds sample count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> n_s2 <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ovf_s2 |-> n_s2 == CNT_W'(MAX_SAMPLES))
		else $error("overflow flagged before store filled");
endmodule

// ----- tb/sv/rmcd_tb_pkg.sv -----
`timescale 1ns / 100ps
// pixel and result types plus the frame scoreboard for the red mask change detector test
package rmcd_tb_pkg;
	import rmcd_pkg::*;

	typedef struct packed {
		bit            cmd;
		bit [CH_W-1:0] red;
		bit [CH_W-1:0] green;
		bit [CH_W-1:0] blue;
		bit            last;
	} pixel_t;

	typedef struct packed {
		bit                 present;
		bit                 similar;
		bit [OUT_CNT_W-1:0] red_count;
		bit [OUT_CNT_W-1:0] match_count;
		bit [OUT_CNT_W-1:0] sample_count;
		bit                 overflow;
	} frame_result_t;

	class frame_scoreboard;
		bit [PCT_W-1:0] redness_pct;
		bit [PCT_W-1:0] similarity_pct;
		bit [PML_W-1:0] presence_pml;

		bit          ref_mask[MAX_SAMPLES];
		int unsigned position;
		int unsigned red_tally;
		int unsigned match_tally;
		bit          overflowed;

		frame_result_t pending[$];
		int errors;
		int pixels_seen;
		int frames_checked;
		int overflow_frames;
		int similar_seen;
		int present_seen;

		function new();
			redness_pct    = REDNESS_RST;
			similarity_pct = SIMILARITY_RST;
			presence_pml   = PRESENCE_RST;
			position       = 0;
			red_tally      = 0;
			match_tally    = 0;
			overflowed     = 0;
			errors         = 0;
			pixels_seen    = 0;
			frames_checked = 0;
			overflow_frames = 0;
			similar_seen   = 0;
			present_seen   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_REDNESS: begin
					redness_pct = val[PCT_W-1:0];
				end
				CFG_SIMILARITY: begin
					similarity_pct = val[PCT_W-1:0];
				end
				CFG_PRESENCE: begin
					presence_pml = val[PML_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// classify one accepted pixel and close the frame on last
		function void note_pixel(pixel_t p);
			int unsigned   rv;
			int unsigned   gv;
			int unsigned   bv;
			bit            mark;
			frame_result_t r;
			rv = 32'(p.red);
			gv = 32'(p.green);
			bv = 32'(p.blue);
			pixels_seen++;
			if (position < MAX_SAMPLES) begin
				mark = rv * 100 > redness_pct * (rv + gv + bv);
				if (mark)
					red_tally++;
				if (p.cmd == CMD_STORE)
					ref_mask[position] = mark;
				else if (ref_mask[position] == mark)
					match_tally++;
				position++;
			end else begin
				overflowed = 1'b1;
			end
			if (p.last) begin
				r.present      = red_tally * 1000 > presence_pml * position;
				r.similar      = (p.cmd == CMD_COMPARE) &&
					(match_tally * 100 > similarity_pct * position);
				r.red_count    = red_tally[OUT_CNT_W-1:0];
				r.match_count  = (p.cmd == CMD_COMPARE) ? match_tally[OUT_CNT_W-1:0] : '0;
				r.sample_count = position[OUT_CNT_W-1:0];
				r.overflow     = overflowed;
				pending = {pending, r};
				position    = 0;
				red_tally   = 0;
				match_tally = 0;
				overflowed  = 1'b0;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			int unsigned   e[6];
			int unsigned   a[6];
			string         field[6];
			if (pending.size() == 0) begin
				$display("%0t: result with no frame pending, got %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			frames_checked++;
			if (want.overflow)
				overflow_frames++;
			if (want.similar)
				similar_seen++;
			if (want.present)
				present_seen++;
			field = '{"present", "similar", "red_count", "match_count", "sample_count",
				"overflow"};
			e = '{32'(want.present), 32'(want.similar), 32'(want.red_count),
				32'(want.match_count), 32'(want.sample_count), 32'(want.overflow)};
			a = '{32'(got.present), 32'(got.similar), 32'(got.red_count),
				32'(got.match_count), 32'(got.sample_count), 32'(got.overflow)};
			for (int i = 0; i < 6; i++) begin
				if (e[i] != a[i]) begin
					$display("%0t: %s expected %0d, actual %0d", $time, field[i], e[i], a[i]);
					errors++;
				end
			end
		endfunction
	endclass

endpackage

// ----- tb/sv/red_mask_change_detector_test.sv -----
`timescale 1ns / 100ps
// top level test of the red mask change detector with random frames and threshold settings
module red_mask_change_detector_test;
	import rmcd_pkg::*;
	import rmcd_tb_pkg::*;

	localparam int WATCH_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_PIXELS = 66;

	typedef enum {FR_STORE, FR_COMPARE, FR_MIXED} frame_kind_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rmcd_pixel_if  pix();
	rmcd_result_if res();

	red_mask_change_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	frame_scoreboard sb;
	bit              no_gaps;
	bit              written[MAX_SAMPLES];
	pixel_t          scene[MAX_SAMPLES];
	int              frame_pos;
	int              sent_items;
	int              settings_applied;
	int              idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// acceptance happens at the next rising edge, inputs only move on rising edges
	always @(negedge clk) begin
		if (pix.valid && pix.ready)
			sb.note_pixel('{pix.cmd, pix.red, pix.green, pix.blue, pix.last});
		if (res.valid && res.ready)
			sb.check_result('{res.present, res.similar, res.red_count, res.match_count,
				res.sample_count, res.overflow});
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("timeout after %0d cycles with no handshake", idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		res.ready <= no_gaps || ($urandom_range(99) >= 27);
	end

	function automatic pixel_t random_color();
		pixel_t p;
		p = '0;
		case ($urandom_range(4))
			0: begin
				p.red   = CH_W'($urandom_range(255));
				p.green = CH_W'($urandom_range(255));
				p.blue  = CH_W'($urandom_range(255));
			end
			1: begin
				p.red   = CH_W'($urandom_range(128, 255));
				p.green = CH_W'($urandom_range(80));
				p.blue  = CH_W'($urandom_range(80));
			end
			2: begin
			end
			3: begin
				p.red   = CH_W'($urandom_range(255));
				p.green = p.red;
				p.blue  = p.red;
			end
			default: begin
				p.red   = CH_W'($urandom_range(255));
				p.green = CH_W'($urandom_range(60));
				p.blue  = CH_W'($urandom_range(60));
			end
		endcase
		return p;
	endfunction

	function automatic pixel_t px(bit c, int r, int g, int b, int l);
		pixel_t p;
		p.cmd   = c;
		p.red   = CH_W'(r);
		p.green = CH_W'(g);
		p.blue  = CH_W'(b);
		p.last  = 1'(l);
		return p;
	endfunction

	task automatic put_pixel(input pixel_t p);
		bit took;
		if (p.cmd == CMD_STORE && frame_pos < MAX_SAMPLES) begin
			written[frame_pos] = 1'b1;
			scene[frame_pos]   = p;
		end
		frame_pos  = p.last ? 0 : frame_pos + 1;
		sent_items++;
		while (!no_gaps && $urandom_range(99) < 27) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.cmd   <= p.cmd;
		pix.red   <= p.red;
		pix.green <= p.green;
		pix.blue  <= p.blue;
		pix.last  <= p.last;
		do begin
			@(negedge clk);
			took = pix.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_frame(input frame_kind_e kind, input int len);
		pixel_t p;
		for (int i = 0; i < len; i++) begin
			if (kind == FR_COMPARE && i < MAX_SAMPLES && $urandom_range(99) < 85)
				p = scene[i];
			else
				p = random_color();
			case (kind)
				FR_STORE:   p.cmd = CMD_STORE;
				FR_COMPARE: p.cmd = CMD_COMPARE;
				default:    p.cmd = 1'($urandom_range(1));
			endcase
			// never compare against a mask entry that was not stored
			if (p.cmd == CMD_COMPARE && i < MAX_SAMPLES && !written[i])
				p.cmd = CMD_STORE;
			p.last = (i == len - 1);
			put_pixel(p);
		end
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_thresholds(input bit [PCT_W-1:0] rp, input bit [PCT_W-1:0] sp,
		input bit [PML_W-1:0] pm);
		logic [CFG_IDX_W-1:0]  idx[3];
		bit   [CFG_DATA_W-1:0] val[3];
		idx = '{CFG_REDNESS, CFG_SIMILARITY, CFG_PRESENCE};
		val = '{CFG_DATA_W'(rp), CFG_DATA_W'(sp), CFG_DATA_W'(pm)};
		for (int i = 0; i < 3; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	task automatic random_frames(input int count);
		int          start;
		int          len;
		int unsigned pick;
		start = sent_items;
		while (sent_items - start < count) begin
			pick = $urandom_range(99);
			len  = ($urandom_range(99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 64);
			if (pick < 25) begin
				send_frame(FR_STORE, len);
			end else if (pick < 85) begin
				while (len > 1 && !written[len-1])
					len--;
				send_frame(FR_COMPARE, len);
			end else begin
				send_frame(FR_MIXED, len);
			end
		end
		drain();
	endtask

	initial begin
		sb               = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pix.valid        = 1'b0;
		pix.cmd          = 1'b0;
		pix.red          = '0;
		pix.green        = '0;
		pix.blue         = '0;
		pix.last         = 1'b0;
		res.ready        = 1'b0;
		no_gaps          = 1'b0;
		frame_pos        = 0;
		sent_items       = 0;
		settings_applied = 0;
		idle_cycles      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reference with black, white, pure red and both sides of the 60 percent edge
		put_pixel(px(CMD_STORE, 0, 0, 0, 0));
		put_pixel(px(CMD_STORE, 255, 0, 0, 0));
		put_pixel(px(CMD_STORE, 255, 255, 255, 0));
		put_pixel(px(CMD_STORE, 153, 51, 51, 0));
		put_pixel(px(CMD_STORE, 154, 51, 51, 0));
		put_pixel(px(CMD_STORE, 0, 255, 255, 1));
		put_pixel(px(CMD_COMPARE, 0, 0, 0, 0));
		put_pixel(px(CMD_COMPARE, 0, 0, 255, 0));
		put_pixel(px(CMD_COMPARE, 255, 255, 255, 0));
		put_pixel(px(CMD_COMPARE, 153, 51, 51, 0));
		put_pixel(px(CMD_COMPARE, 154, 51, 51, 0));
		put_pixel(px(CMD_COMPARE, 0, 255, 255, 1));
		// one-sample store right before a compare of the same entry
		no_gaps = 1'b1;
		put_pixel(px(CMD_STORE, 255, 0, 0, 1));
		put_pixel(px(CMD_COMPARE, 255, 0, 0, 1));
		put_pixel(px(CMD_COMPARE, 0, 0, 0, 1));
		no_gaps = 1'b0;
		// mixed roles, closed by a store and then by a compare
		put_pixel(px(CMD_COMPARE, 255, 0, 0, 0));
		put_pixel(px(CMD_STORE, 0, 255, 0, 0));
		put_pixel(px(CMD_COMPARE, 0, 0, 0, 0));
		put_pixel(px(CMD_STORE, 200, 10, 10, 0));
		put_pixel(px(CMD_STORE, 255, 255, 0, 1));
		put_pixel(px(CMD_STORE, 10, 10, 10, 0));
		put_pixel(px(CMD_COMPARE, 255, 0, 0, 1));
		drain();

		random_frames(PHASE_PIXELS);
		set_thresholds(7'd0, 7'd0, 10'd0);
		random_frames(PHASE_PIXELS);
		set_thresholds(7'd100, 7'd100, 10'd1000);
		random_frames(PHASE_PIXELS);
		set_thresholds(7'd127, 7'd127, 10'd1023);
		random_frames(PHASE_PIXELS);
		repeat (2) begin
			set_thresholds(PCT_W'($urandom_range(20, 80)), PCT_W'($urandom_range(40, 100)),
				PML_W'($urandom_range(0, 1000)));
			random_frames(PHASE_PIXELS);
		end

		// a long run with no idling on either side
		set_thresholds(REDNESS_RST, SIMILARITY_RST, PRESENCE_RST);
		no_gaps = 1'b1;
		random_frames(PHASE_PIXELS);
		no_gaps = 1'b0;

		$display("checked %0d frames from %0d pixels, %0d of them past the store depth",
			sb.frames_checked, sb.pixels_seen, sb.overflow_frames);
		$display("%0d threshold settings, %0d similar and %0d present verdicts",
			settings_applied, sb.similar_seen, sb.present_seen);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
